// ----- rtl/core/lctc_pkg.sv -----
// shared types and constants for the line crossing track counter
// no dependencies; every other file depends on this package
`default_nettype none

package lctc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int HISTORY_DEPTH = 5;
    localparam int NUM_CLASSES   = 8;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int CLS_W     = 3;
    localparam int ID_W      = 32;
    localparam int X_W       = 16;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 32;
    localparam int ENTRIES_W = 7;
    localparam int MASK_W    = 8;
    localparam int THR_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_THR    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FRAME = 2'd3;

    localparam logic OP_OBSERVE   = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    typedef logic [HISTORY_DEPTH-1:0][CLS_W-1:0] hist_t;

    typedef struct packed {
        logic [ID_W-1:0]   obj_id;
        hist_t             hist;
        logic [FILL_W-1:0] fill;
        logic              crossed_last;
    } rec_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic vote;
        logic frame;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic frame_op;
        logic tracked;
        logic idx_last;
        logic need_vote;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/lctc_if.sv -----
// valid/ready channel interfaces for observations and results
// depends on lctc_pkg
`default_nettype none

interface lctc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [lctc_pkg::ID_W-1:0]          obj_id;
    logic [lctc_pkg::CLS_W-1:0]         obj_class;
    logic signed [lctc_pkg::X_W-1:0]    left_x;
    logic signed [lctc_pkg::X_W-1:0]    right_x;
    logic                               is_tracked;

    modport source (output valid, operation, obj_id, obj_class, left_x, right_x, is_tracked,
                    input ready);
    modport sink   (input valid, operation, obj_id, obj_class, left_x, right_x, is_tracked,
                    output ready);
endinterface

interface lctc_out_if;
    logic                               valid;
    logic                               ready;
    logic [lctc_pkg::STATUS_W-1:0]      status;
    logic [lctc_pkg::CLS_W-1:0]         counted_class;
    logic [lctc_pkg::TOTAL_W-1:0]       class_total;
    logic [lctc_pkg::ENTRIES_W-1:0]     entries_in_use;

    modport source (output valid, status, counted_class, class_total, entries_in_use,
                    input ready);
    modport sink   (input valid, status, counted_class, class_total, entries_in_use,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lctc_datapath.sv -----
// track table, vote logic, class totals and result register
// depends on lctc_pkg; driven by lctc_ctrl through cmd_t / sts_t
`default_nettype none

module lctc_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lctc_pkg::cmd_t                 cmd,
    output lctc_pkg::sts_t                      sts,
    input  wire logic                           cfg_we,
    input  wire logic [lctc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lctc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_operation,
    input  wire logic [lctc_pkg::ID_W-1:0]      in_obj_id,
    input  wire logic [lctc_pkg::CLS_W-1:0]     in_obj_class,
    input  wire logic [lctc_pkg::X_W-1:0]       in_left_x,
    input  wire logic [lctc_pkg::X_W-1:0]       in_right_x,
    input  wire logic                           in_is_tracked,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lctc_pkg::STATUS_W-1:0]       out_status,
    output logic [lctc_pkg::CLS_W-1:0]          out_counted_class,
    output logic [lctc_pkg::TOTAL_W-1:0]        out_class_total,
    output logic [lctc_pkg::ENTRIES_W-1:0]      out_entries_in_use
);
    import lctc_pkg::*;

    // latched item
    logic                   op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [CLS_W-1:0]       cls_reg, cls_next;
    logic signed [X_W-1:0]  lx_reg, lx_next;
    logic signed [X_W-1:0]  rx_reg, rx_next;
    logic                   trk_reg, trk_next;

    logic signed [X_W-1:0]  scan_x_reg, scan_x_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic [THR_W-1:0]       thr_reg, thr_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    rec_t                   rdata_reg;

    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    rec_t                   hit_rec_reg, hit_rec_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;

    logic [CLS_W-1:0]       best_c_reg, best_c_next;
    logic [FILL_W-1:0]      best_n_reg, best_n_next;
    logic [TOTAL_W-1:0]     totals_reg [NUM_CLASSES];
    logic [TOTAL_W-1:0]     totals_next [NUM_CLASSES];

    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [CLS_W-1:0]       res_cls_reg, res_cls_next;
    logic [TOTAL_W-1:0]     res_total_reg, res_total_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [CLS_W-1:0]       out_cls_reg, out_cls_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic [ENTRIES_W-1:0]   out_entries_reg, out_entries_next;

    rec_t                   mem [TABLE_ENTRIES];
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    rec_t                   mem_wdata;

    // decide-cycle terms
    logic                   pass;
    logic                   have_entry;
    logic [IDX_W-1:0]       ent;
    rec_t                   base;
    logic                   crossing;
    hist_t                  hist_new;
    logic [FILL_W-1:0]      fill_new;
    logic [FILL_W-1:0]      vote_n;
    logic [CLS_W-1:0]       vote_c;
    logic [FILL_W-1:0]      cnt_c;
    logic                   need_vote;
    logic [TOTAL_W-1:0]     tot_cur;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_comb
    begin
        pass       = (32'(cls_reg) < NUM_CLASSES) && mask_reg[cls_reg];
        have_entry = hit_reg || free_reg;
        ent        = hit_reg ? hit_idx_reg : free_idx_reg;
        if (hit_reg)
        begin
            base = hit_rec_reg;
        end
        else
        begin
            base        = '0;
            base.obj_id = id_reg;
        end
        crossing = (lx_reg <= scan_x_reg) && (rx_reg >= scan_x_reg);

        // push class into history: append while filling, else shift out oldest
        hist_new = base.hist;
        fill_new = base.fill;
        if (32'(base.fill) < HISTORY_DEPTH)
        begin
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                if (32'(base.fill) == k)
                begin
                    hist_new[k] = cls_reg;
                end
            end
            fill_new = base.fill + FILL_W'(1);
        end
        else
        begin
            for (int k = 0; k < HISTORY_DEPTH - 1; k++)
            begin
                hist_new[k] = base.hist[k + 1];
            end
            hist_new[HISTORY_DEPTH-1] = cls_reg;
        end

        // majority, lowest class wins a tie
        vote_n = '0;
        vote_c = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            cnt_c = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
            begin
                if ((k < 32'(fill_new)) && (hist_new[k] == CLS_W'(c)))
                begin
                    cnt_c = cnt_c + FILL_W'(1);
                end
            end
            if (cnt_c > vote_n)
            begin
                vote_n = cnt_c;
                vote_c = CLS_W'(c);
            end
        end

        need_vote = trk_reg && pass && have_entry && crossing && !base.crossed_last;
        tot_cur   = totals_reg[best_c_reg];
    end

    always_comb
    begin
        op_next          = op_reg;
        id_next          = id_reg;
        cls_next         = cls_reg;
        lx_next          = lx_reg;
        rx_next          = rx_reg;
        trk_next         = trk_reg;
        scan_x_next      = scan_x_reg;
        mask_next        = mask_reg;
        thr_next         = thr_reg;
        valid_next       = valid_reg;
        seen_next        = seen_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_rec_next     = hit_rec_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        best_c_next      = best_c_reg;
        best_n_next      = best_n_reg;
        totals_next      = totals_reg;
        res_status_next  = res_status_reg;
        res_cls_next     = res_cls_reg;
        res_total_next   = res_total_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_cls_next     = out_cls_reg;
        out_total_next   = out_total_reg;
        out_entries_next = out_entries_reg;
        mem_we           = 1'b0;
        mem_waddr        = ent;
        mem_wdata        = base;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCAN_LINE_X: scan_x_next = cfg_data;
                REG_CLASS_MASK:  mask_next   = cfg_data[MASK_W-1:0];
                REG_VOTE_THR:    thr_next    = cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end

        if (cmd.load)
        begin
            op_next         = in_operation;
            id_next         = in_obj_id;
            cls_next        = in_obj_class;
            lx_next         = in_left_x;
            rx_next         = in_right_x;
            trk_next        = in_is_tracked;
            idx_next        = '0;
            hit_next        = 1'b0;
            free_next       = 1'b0;
            res_status_next = ST_NONE;
            res_cls_next    = '0;
            res_total_next  = '0;
        end

        if (cmd.scan)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (!free_reg && !valid_reg[idx_reg])
            begin
                free_next     = 1'b1;
                free_idx_next = idx_reg;
            end
        end

        // compare the entry read in the previous cycle
        if (cmp_vld_reg && !hit_reg && valid_reg[cmp_idx_reg] && (rdata_reg.obj_id == id_reg))
        begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
            hit_rec_next = rdata_reg;
        end

        if (cmd.decide)
        begin
            if (!pass)
            begin
                if (hit_reg)
                begin
                    seen_next[ent] = 1'b1;
                end
            end
            else if (!have_entry)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                if (!hit_reg)
                begin
                    valid_next[ent] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                seen_next[ent]         = 1'b1;
                mem_we                 = 1'b1;
                mem_wdata.obj_id       = id_reg;
                mem_wdata.hist         = hist_new;
                mem_wdata.fill         = fill_new;
                mem_wdata.crossed_last = crossing;
                best_c_next            = vote_c;
                best_n_next            = vote_n;
            end
        end

        if (cmd.vote)
        begin
            if (32'(best_n_reg) >= 32'(thr_reg))
            begin
                if (tot_cur != '1)
                begin
                    totals_next[best_c_reg] = tot_cur + TOTAL_W'(1);
                    res_total_next          = tot_cur + TOTAL_W'(1);
                end
                else
                begin
                    res_total_next = tot_cur;
                end
                res_status_next = ST_COUNT;
                res_cls_next    = best_c_reg;
            end
        end

        if (cmd.frame)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (valid_reg[idx_reg] && !seen_reg[idx_reg])
            begin
                valid_next[idx_reg] = 1'b0;
                count_next          = count_reg - CNT_W'(1);
            end
            seen_next[idx_reg] = 1'b0;
            res_status_next    = ST_FRAME;
        end

        if (cmd.emit)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = res_status_reg;
            out_cls_next     = res_cls_reg;
            out_total_next   = res_total_reg;
            out_entries_next = ENTRIES_W'(count_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= OP_OBSERVE;
            id_reg          <= '0;
            cls_reg         <= '0;
            lx_reg          <= '0;
            rx_reg          <= '0;
            trk_reg         <= 1'b0;
            scan_x_reg      <= '0;
            mask_reg        <= '1;
            thr_reg         <= THR_W'(3);
            valid_reg       <= '0;
            seen_reg        <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            hit_rec_reg     <= '0;
            free_reg        <= 1'b0;
            free_idx_reg    <= '0;
            best_c_reg      <= '0;
            best_n_reg      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                totals_reg[c] <= '0;
            end
            res_status_reg  <= ST_NONE;
            res_cls_reg     <= '0;
            res_total_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_NONE;
            out_cls_reg     <= '0;
            out_total_reg   <= '0;
            out_entries_reg <= '0;
        end
        else
        begin
            op_reg          <= op_next;
            id_reg          <= id_next;
            cls_reg         <= cls_next;
            lx_reg          <= lx_next;
            rx_reg          <= rx_next;
            trk_reg         <= trk_next;
            scan_x_reg      <= scan_x_next;
            mask_reg        <= mask_next;
            thr_reg         <= thr_next;
            valid_reg       <= valid_next;
            seen_reg        <= seen_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            cmp_vld_reg     <= cmd.scan;
            cmp_idx_reg     <= idx_reg;
            hit_reg         <= hit_next;
            hit_idx_reg     <= hit_idx_next;
            hit_rec_reg     <= hit_rec_next;
            free_reg        <= free_next;
            free_idx_reg    <= free_idx_next;
            best_c_reg      <= best_c_next;
            best_n_reg      <= best_n_next;
            totals_reg      <= totals_next;
            res_status_reg  <= res_status_next;
            res_cls_reg     <= res_cls_next;
            res_total_reg   <= res_total_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_cls_reg     <= out_cls_next;
            out_total_reg   <= out_total_next;
            out_entries_reg <= out_entries_next;
        end
    end

    always_comb
    begin
        sts.frame_op  = (op_reg == OP_FRAME_END);
        sts.tracked   = trk_reg;
        sts.idx_last  = (32'(idx_reg) == TABLE_ENTRIES - 1);
        sts.need_vote = need_vote;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_counted_class  = out_cls_reg;
    assign out_class_total    = out_total_reg;
    assign out_entries_in_use = out_entries_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lctc_ctrl.sv -----
// sequencer for scan, update, vote and frame purge
// depends on lctc_pkg; commands lctc_datapath
`default_nettype none

module lctc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output lctc_pkg::cmd_t      cmd,
    input  wire lctc_pkg::sts_t sts
);
    import lctc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_VOTE,
        S_FRAME,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.frame_op)
                begin
                    state_next = S_FRAME;
                end
                else if (!sts.tracked)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            // last read still in flight
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.need_vote ? S_VOTE : S_FINISH;
            end
            S_VOTE:
            begin
                cmd.vote   = 1'b1;
                state_next = S_FINISH;
            end
            S_FRAME:
            begin
                cmd.frame = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/line_crossing_track_counter_top.sv -----
// sequence: an observation passes dispatch, an id search of one entry per cycle over all
// TABLE_ENTRIES entries, scan end, decide, a vote when a crossing goes to one, and finish;
// a frame end: dispatch, a purge of every entry, finish; untracked: dispatch, finish
// throughput: one item at a time; the next item is taken in the cycle after the result is
// registered, and a finished beat waits in the output register while the next item runs
// reset: asynchronous, clears table valid bits, totals and registers; depends on lctc_pkg, lctc_if
`default_nettype none

module line_crossing_track_counter_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lctc_in_if.sink                             in_ch,
    lctc_out_if.source                          out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [lctc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lctc_pkg::CFG_W-1:0]     cfg_data
);
    import lctc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lctc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lctc_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_operation       (in_ch.operation),
        .in_obj_id          (in_ch.obj_id),
        .in_obj_class       (in_ch.obj_class),
        .in_left_x          (in_ch.left_x),
        .in_right_x         (in_ch.right_x),
        .in_is_tracked      (in_ch.is_tracked),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .out_status         (out_ch.status),
        .out_counted_class  (out_ch.counted_class),
        .out_class_total    (out_ch.class_total),
        .out_entries_in_use (out_ch.entries_in_use)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lctc_checker.sv -----
// port-level checks for the line crossing track counter, bound to the top level
// depends on lctc_pkg
`default_nettype none

module lctc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [lctc_pkg::STATUS_W-1:0]  status,
    input wire logic [lctc_pkg::CLS_W-1:0]     counted_class,
    input wire logic [lctc_pkg::TOTAL_W-1:0]   class_total,
    input wire logic [lctc_pkg::ENTRIES_W-1:0] entries_in_use
);
    import lctc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(class_total))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_COUNT |-> counted_class == '0 && class_total == '0)
        else $error("class fields set without a count");

    a_entries_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(entries_in_use) <= TABLE_ENTRIES)
        else $error("entries in use above table size");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> 32'(entries_in_use) == TABLE_ENTRIES)
        else $error("drop reported with free entries");

endmodule

bind line_crossing_track_counter_top lctc_checker u_lctc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .counted_class  (out_ch.counted_class),
    .class_total    (out_ch.class_total),
    .entries_in_use (out_ch.entries_in_use)
);

`default_nettype wire
